// File: rtl/swlrl_pkg.sv
// Package: sizes, types and constants of the sliding window log rate limiter.
`timescale 1ns / 1ps
package swlrl_pkg;
  localparam int CLIENTS = 16;
  localparam int RING_DEPTH = 64;
  localparam int TIME_BITS = 32;
  localparam int CID_W = 4;
  localparam int CLI_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int ADDR_W = CLI_W + PTR_W;
  localparam int MEM_DEPTH = CLIENTS * RING_DEPTH;
  localparam int WIN_W = 31;
  localparam int LIM_W = 7;
  localparam int OCC_W = 7;
  localparam int QDEPTH = 2;
  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef struct packed {
    logic [CLI_W-1:0]     client;
    logic [TIME_BITS-1:0] now;
  } req_t;

  typedef struct packed {
    logic             allowed;
    logic [OCC_W-1:0] occupancy;
    logic             overflow;
  } res_t;
endpackage

// File: rtl/swlrl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module swlrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/swlrl_front.sv
// Front end: accept requests, fold client index and time, queue them.
`timescale 1ns / 1ps
module swlrl_front
  import swlrl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [CID_W-1:0]     client_id,
  input  logic [TIME_BITS-1:0] now_time,
  output logic                 req_valid,
  output req_t                 req,
  input  logic                 req_take
);
  req_t q_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(QDEPTH+1)-1:0] cnt_r;
  req_t item;
  logic do_push, do_pop;

  always_comb begin
    item.client = CLI_W'(32'(client_id) % CLIENTS);
    item.now = now_time;
  end

  assign full = (cnt_r == ($clog2(QDEPTH+1))'(QDEPTH));
  assign req_valid = (cnt_r != '0);
  assign req = q_r[rp_r];
  assign do_push = push && !full;
  assign do_pop = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= item;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end
  end
endmodule

// File: rtl/swlrl_back.sv
// Back end: evict expired records, decide, append, hold one result.
`timescale 1ns / 1ps
module swlrl_back
  import swlrl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  req_t             req,
  output logic             req_take,
  input  logic [WIN_W-1:0] window,
  input  logic [LIM_W-1:0] limit,
  output logic             res_valid,
  output res_t             res,
  input  logic             res_take
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [PTR_W-1:0] head_r [CLIENTS];
  logic [CNT_W-1:0] cnt_r [CLIENTS];
  req_t cur_r;
  logic [PTR_W-1:0] h_r, h_nxt;
  logic [CNT_W-1:0] c_r, c_nxt;
  logic res_valid_r;
  res_t res_r;
  logic [TIME_BITS-1:0] rdata, age;
  logic we;
  logic [ADDR_W-1:0] raddr, waddr;
  logic expired, full_ring;
  logic [PTR_W-1:0] tail;

  swlrl_ram #(.WIDTH(TIME_BITS), .DEPTH(MEM_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(cur_r.now),
    .raddr(raddr), .rdata(rdata)
  );

  assign age = cur_r.now - rdata;
  assign expired = (age > TIME_BITS'(window));
  assign full_ring = (c_r == CNT_W'(RING_DEPTH));
  assign tail = PTR_W'(32'(h_r) + 32'(c_r));
  assign raddr = {cur_r.client, h_nxt};
  assign waddr = {cur_r.client, tail};
  assign req_take = (st_r == S_IDLE) && req_valid;
  assign res_valid = res_valid_r;
  assign res = res_r;

  always_comb begin
    st_nxt = st_r;
    h_nxt = h_r;
    c_nxt = c_r;
    we = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (req_valid) st_nxt = S_READ;
      end
      S_READ: st_nxt = S_CHECK;
      S_CHECK: begin
        if (c_r != '0 && expired) begin
          h_nxt = h_r + 1'b1;
          c_nxt = c_r - 1'b1;
          st_nxt = S_READ;
        end else if (!res_valid_r || res_take) begin
          we = !full_ring;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid_r || res_take) begin
          we = !full_ring;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cur_r <= req;
      h_r <= head_r[req.client];
      c_r <= cnt_r[req.client];
    end else begin
      h_r <= h_nxt;
      c_r <= c_nxt;
    end
    if (we || (st_nxt == S_IDLE && st_r != S_IDLE)) begin
      res_r.allowed <= (32'(c_r) < 32'(limit));
      res_r.occupancy <= OCC_W'(full_ring ? 32'(c_r) : 32'(c_r) + 1);
      res_r.overflow <= full_ring;
    end
    if (!rst_n) begin
      st_r <= S_IDLE;
      res_valid_r <= 1'b0;
      for (int i = 0; i < CLIENTS; i++) begin
        head_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (st_nxt == S_IDLE && st_r != S_IDLE) begin
        res_valid_r <= 1'b1;
        head_r[cur_r.client] <= h_r;
        cnt_r[cur_r.client] <= full_ring ? c_r : c_r + 1'b1;
      end else if (res_take) begin
        res_valid_r <= 1'b0;
      end
    end
  end
endmodule

// File: rtl/sliding_window_log_rate_limiter.sv
// Top level of the sliding window log rate limiter.
`timescale 1ns / 1ps
// Requests enter as queue beats: in_push with in_client_id and in_now_time,
// taken when in_full is low. Two requests can wait in the front queue.
// Results leave as queue beats: out_allowed, out_occupancy and out_overflow
// are valid while out_empty is low and are taken by out_pop.
// Configuration: cfg_we with cfg_index 0 writes the window length,
// index 1 the request limit; write only while idle.
// The back end takes one request at a time; each record check, one per
// expired record dropped and one more for the record that stays, is one read
// of the timestamp memory (S_READ) plus one compare (S_CHECK).
// The result register takes one result; while it is not popped the back
// end holds its next result and the front queue fills, then in_full rises.
// Reset (synchronous, rst_n low) empties all rings and queues and sets the
// window to 1 and the limit to 10; timestamps are not cleared.
module sliding_window_log_rate_limiter
  import swlrl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [CID_W-1:0]     in_client_id,
  input  logic [TIME_BITS-1:0] in_now_time,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_allowed,
  output logic [OCC_W-1:0]     out_occupancy,
  output logic                 out_overflow,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [WIN_W-1:0]     cfg_data
);
  logic [WIN_W-1:0] window_r;
  logic [LIM_W-1:0] limit_r;
  logic req_valid, req_take, res_valid;
  req_t req;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_W'(1);
      limit_r <= LIM_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW: window_r <= cfg_data;
        CFG_LIMIT: limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  swlrl_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .full(in_full),
    .client_id(in_client_id), .now_time(in_now_time),
    .req_valid(req_valid), .req(req), .req_take(req_take)
  );

  swlrl_back u_back (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req(req),
    .req_take(req_take), .window(window_r), .limit(limit_r),
    .res_valid(res_valid), .res(res), .res_take(out_pop)
  );

  assign out_empty = !res_valid;
  assign out_allowed = res.allowed;
  assign out_occupancy = res.occupancy;
  assign out_overflow = res.overflow;
endmodule

// File: tb/tb_top.sv
// Testbench for the sliding window log rate limiter: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import swlrl_pkg::*;

  typedef struct packed {
    logic             allowed;
    logic [OCC_W-1:0] occupancy;
    logic             overflow;
  } verdict_t;

  localparam int EXP_DEPTH = 64;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [CID_W-1:0]     in_client_id = '0;
  logic [TIME_BITS-1:0] in_now_time = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic                 out_allowed;
  logic [OCC_W-1:0]     out_occupancy;
  logic                 out_overflow;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_WINDOW;
  logic [WIN_W-1:0]     cfg_data = '0;

  logic [TIME_BITS-1:0] stamp_mem [CLIENTS][RING_DEPTH];
  int unsigned          oldest_slot [CLIENTS];
  int unsigned          held_count [CLIENTS];
  logic [WIN_W-1:0]     win_len;
  logic [LIM_W-1:0]     limit_val;
  verdict_t             exp_buf [EXP_DEPTH];
  int unsigned          exp_wr = 0;
  int unsigned          exp_rd = 0;
  int                   errors = 0;
  longint               cycles = 0;
  bit                   hold_pop = 1'b0;
  bit                   quiet_pop = 1'b0;
  int unsigned          pop_pause = 0;
  logic [TIME_BITS-1:0] clock_now [CLIENTS];

  sliding_window_log_rate_limiter u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void predict_reset();
    for (int c = 0; c < CLIENTS; c++) begin
      oldest_slot[c] = 0;
      held_count[c] = 0;
      clock_now[c] = '0;
    end
    win_len = 31'd1;
    limit_val = 7'd10;
  endfunction

  function automatic verdict_t predict_request(logic [CID_W-1:0] cid, logic [TIME_BITS-1:0] t);
    int unsigned c, h, n;
    logic [TIME_BITS-1:0] age;
    verdict_t v;
    c = cid % CLIENTS;
    h = oldest_slot[c];
    n = held_count[c];
    while (n > 0) begin
      age = t - stamp_mem[c][h];
      if ({1'b0, age} <= {2'b0, win_len}) break;
      h = (h + 1) % RING_DEPTH;
      n--;
    end
    v.allowed = (n >= limit_val) ? 1'b0 : 1'b1;
    v.overflow = 1'b0;
    if (n >= RING_DEPTH) v.overflow = 1'b1;
    else begin
      stamp_mem[c][(h + n) % RING_DEPTH] = t;
      n++;
    end
    oldest_slot[c] = h;
    held_count[c] = n;
    v.occupancy = n[OCC_W-1:0];
    return v;
  endfunction

  task automatic send_request(logic [CID_W-1:0] cid, logic [TIME_BITS-1:0] t, int gap);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_client_id <= cid;
    in_now_time <= t;
    do @(posedge clk); while (in_full);
    exp_buf[exp_wr % EXP_DEPTH] = predict_request(cid, t);
    exp_wr++;
  endtask

  task automatic write_reg(logic idx, logic [WIN_W-1:0] val);
    in_push <= 1'b0;
    wait (exp_wr == exp_rd);
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WINDOW) win_len = val;
    else limit_val = val[LIM_W-1:0];
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // pop side: random stalls, occasional long pauses and a forced long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else if (pop_pause != 0) begin
      pop_pause <= pop_pause - 1;
      out_pop <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) pop_pause <= $urandom_range(10, 40);
      out_pop <= !hold_pop && (quiet_pop || $urandom_range(0, 99) < 75);
    end
  end

  always @(posedge clk) begin
    verdict_t exp;
    if (rst_n && out_pop && !out_empty) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected beat allowed=%0d occ=%0d ovf=%0d", $time,
                 out_allowed, out_occupancy, out_overflow);
        errors++;
      end else begin
        exp = exp_buf[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_allowed !== exp.allowed) begin
          $display("%0t: allowed exp %0d got %0d", $time, exp.allowed, out_allowed);
          errors++;
        end
        if (out_occupancy !== exp.occupancy) begin
          $display("%0t: occupancy exp %0d got %0d", $time, exp.occupancy, out_occupancy);
          errors++;
        end
        if (out_overflow !== exp.overflow) begin
          $display("%0t: overflow exp %0d got %0d", $time, exp.overflow, out_overflow);
          errors++;
        end
      end
    end
  end

  task automatic test_defaults();
    send_request(4'd0, 32'd0, 0);
    send_request(4'd0, 32'd1, 0);
    send_request(4'd0, 32'd2, 0);
    send_request(4'd0, 32'd3, 0);
    send_request(4'd15, 32'hFFFF_FFFF, 0);
    send_request(4'd15, 32'd0, 0);
    send_request(4'd15, 32'd1, 0);
    send_request(4'd7, 32'h8000_0000, 1);
  endtask

  task automatic test_zero_limit();
    write_reg(CFG_LIMIT, 31'd0);
    write_reg(CFG_WINDOW, 31'h7FFF_FFFF);
    send_request(4'd3, 32'd100, 0);
    send_request(4'd3, 32'd100, 0);
    send_request(4'd9, 32'hA5A5_5A5A, 0);
  endtask

  task automatic test_overflow();
    write_reg(CFG_LIMIT, 31'd64);
    write_reg(CFG_WINDOW, 31'h7FFF_FFFF);
    for (int i = 0; i < 70; i++) send_request(4'd5, 32'd1000 + i, 0);
    write_reg(CFG_LIMIT, 31'd127);
    send_request(4'd5, 32'd1100, 0);
    write_reg(CFG_WINDOW, 31'd0);
    send_request(4'd5, 32'd5000, 0);
    send_request(4'd5, 32'd5000, 0);
  endtask

  task automatic test_backpressure();
    hold_pop <= 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_pop <= 1'b0;
      end
      for (int i = 0; i < 12; i++) send_request(CID_W'($urandom), $urandom, 0);
    join
  endtask

  task automatic random_phase(int n, logic [WIN_W-1:0] w, logic [LIM_W-1:0] l);
    logic [CID_W-1:0] cid;
    write_reg(CFG_WINDOW, w);
    write_reg(CFG_LIMIT, WIN_W'(l));
    quiet_pop <= ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      cid = CID_W'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3));
      if ($urandom_range(0, 19) == 0) clock_now[cid] = $urandom;
      else clock_now[cid] = clock_now[cid] + $urandom_range(0, 2 * w + 2);
      send_request(cid, clock_now[cid], pick_gap());
    end
    quiet_pop <= 1'b0;
  endtask

  initial begin
    predict_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_zero_limit();
    test_overflow();
    test_backpressure();
    random_phase(220, 31'd20, 7'd5);
    random_phase(220, 31'd3, 7'd1);
    random_phase(220, 31'd200, 7'd64);
    random_phase(150, 31'd50, 7'd12);
    random_phase(60, 31'h7FFF_FFFF, 7'd70);
    in_push <= 1'b0;
    wait (exp_wr == exp_rd);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// File: sim.f
rtl/swlrl_pkg.sv
rtl/swlrl_ram.sv
rtl/swlrl_front.sv
rtl/swlrl_back.sv
rtl/sliding_window_log_rate_limiter.sv
tb/tb_top.sv
